/* src/ptw_pkg.sv */
package ptw_pkg;

   localparam int VA_W        = 48;
   localparam int WORD_IDX_W  = 13;
   localparam int DATA_W      = 64;
   localparam int ROOT_W      = 16;
   localparam int MEM_WORDS   = 8192;
   localparam int MEM_BYTES   = 65536;
   localparam int ADDR_W      = 17;
   localparam int PTE_SHIFT   = 3;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 64;

   localparam int VA_LSB      = 0;
   localparam int WIDX_LSB    = VA_LSB + VA_W;
   localparam int WDATA_LSB   = WIDX_LSB + WORD_IDX_W;

   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

endpackage

/* src/radix_page_table_walk.sv */
// results: a write word's result is registered at the acceptance edge; a translation
// issues the root read at the accept edge, then one dependent table memory read per
// level, and registers its result after the last; a fault ends the walk at the level that fails
// throughput: one word in flight; a write every cycle and a new translation once the
// walk ends, each slower while rsp_tready low holds the result register
// reset: synchronous; a clearing pass writes zero to all 8192 table words, one a cycle,
// with req_tready low; csr writes are taken throughout
module radix_page_table_walk #(
   parameter int LEVEL_COUNT    = 4,
   parameter int OFFSET_BITS    = 12,
   parameter int PHYS_ADDR_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // virt_addr[47:0], word_index[60:48], word_data[124:61], zero fill
   input  logic [ptw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // trans_addr[63:0]
   output logic [ptw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // fault
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [ptw_pkg::ROOT_W-1:0]      csr_wdata
);

   import ptw_pkg::*;

   localparam int INDEX_BITS = OFFSET_BITS - PTE_SHIFT;
   localparam int VPN_W      = LEVEL_COUNT * INDEX_BITS;
   localparam int EXT_W      = VPN_W + OFFSET_BITS + VA_W;
   localparam int LVL_W      = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam logic [63:0] PHYS_LIM = (64'd1 << PHYS_ADDR_BITS);
   localparam logic [63:0] LIMIT    = (PHYS_LIM < 64'(MEM_BYTES)) ? PHYS_LIM : 64'(MEM_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LIMIT - 64'd8);
   localparam logic [DATA_W-1:0] OFF_MASK  = (64'd1 << OFFSET_BITS) - 64'd1;
   localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVEL_COUNT - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [WORD_IDX_W-1:0]   clr_ff, clr_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic [VPN_W-1:0]        vpn_ff, vpn_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic [DATA_W-1:0]       res_addr_ff, res_addr_in;
   logic                    res_fault_ff, res_fault_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_fault_ff, rsp_fault_in;

   logic [VA_W-1:0]         req_va;
   logic [WORD_IDX_W-1:0]   req_widx;
   logic [DATA_W-1:0]       req_wdata;
   logic [EXT_W-1:0]        va_ext;
   logic [VPN_W-1:0]        vpn_new;
   logic                    accept;
   logic                    out_free;

   logic [DATA_W-1:0]       next_base;
   logic [DATA_W-1:0]       base_sel;
   logic [INDEX_BITS-1:0]   idx_sel;
   logic [ADDR_W-1:0]       entry_addr;
   logic                    chk_fault;

   logic                    ram_we;
   logic [WORD_IDX_W-1:0]   ram_waddr;
   logic [DATA_W-1:0]       ram_wdata;
   logic [WORD_IDX_W-1:0]   ram_raddr;
   logic [DATA_W-1:0]       ram_rdata;

   logic                    fin;
   logic [DATA_W-1:0]       fin_addr;
   logic                    fin_fault;

   assign req_va    = req_tdata[VA_LSB +: VA_W];
   assign req_widx  = req_tdata[WIDX_LSB +: WORD_IDX_W];
   assign req_wdata = req_tdata[WDATA_LSB +: DATA_W];
   assign va_ext    = EXT_W'(req_va);
   assign vpn_new   = va_ext[OFFSET_BITS +: VPN_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // entry address and range check shared by root and later levels
   assign next_base  = ram_rdata & ~OFF_MASK;
   assign base_sel   = (state_ff == ST_IDLE) ? DATA_W'(root_ff) : next_base;
   assign idx_sel    = (state_ff == ST_IDLE) ? vpn_new[VPN_W-1 -: INDEX_BITS]
                                             : vpn_ff[VPN_W-1 -: INDEX_BITS];
   assign entry_addr = {1'b0, base_sel[15:0]} + (ADDR_W'(idx_sel) << PTE_SHIFT);
   assign chk_fault  = (base_sel >= LIMIT) || (entry_addr > LAST_ADDR);
   assign ram_raddr  = entry_addr[PTE_SHIFT +: WORD_IDX_W];

   assign ram_we    = (state_ff == ST_CLEAR) || (accept && (req_tuser == OP_WRITE));
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : req_widx;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : req_wdata;

   ptw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      root_in      = csr_we ? csr_wdata : root_ff;
      lvl_in       = lvl_ff;
      vpn_in       = vpn_ff;
      off_in       = off_ff;
      res_addr_in  = res_addr_ff;
      res_fault_in = res_fault_ff;
      fin          = 1'b0;
      fin_addr     = '0;
      fin_fault    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_WRITE) begin
                  fin = 1'b1;
               end else if ((root_ff == '0) || chk_fault) begin
                  fin       = 1'b1;
                  fin_fault = 1'b1;
               end else begin
                  lvl_in   = '0;
                  vpn_in   = vpn_new << INDEX_BITS;
                  off_in   = req_va[OFFSET_BITS-1:0];
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!ram_rdata[0]) begin
               fin       = 1'b1;
               fin_fault = 1'b1;
            end else if (lvl_ff == LAST_LVL) begin
               fin      = 1'b1;
               fin_addr = next_base | DATA_W'(off_ff);
            end else if (chk_fault) begin
               fin       = 1'b1;
               fin_fault = 1'b1;
            end else begin
               lvl_in = lvl_ff + 1'b1;
               vpn_in = vpn_ff << INDEX_BITS;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         res_addr_in  = fin_addr;
         res_fault_in = fin_fault;
         state_in     = out_free ? ST_IDLE : ST_DONE;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_fault_in = rsp_fault_ff;
      if (fin && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_addr;
         rsp_fault_in = fin_fault;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_addr_ff;
         rsp_fault_in = res_fault_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff       <= lvl_in;
      vpn_ff       <= vpn_in;
      off_ff       <= off_in;
      res_addr_ff  <= res_addr_in;
      res_fault_ff <= res_fault_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fault_ff;

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !ram_we)
      else $error("table write during walk");

   a_fault_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_data_ff == '0))
      else $error("fault word with nonzero address");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (lvl_ff <= LAST_LVL))
      else $error("walk level out of range");

   a_done_holds_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> rsp_valid_ff)
      else $error("pending result without occupied output");

endmodule

/* src/ptw_ram.sv */
module ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/radix_page_table_walk_test.sv */
`timescale 1ns / 100ps

module radix_page_table_walk_test;
   import ptw_pkg::*;

   localparam int LEVELS    = 4;
   localparam int OFFSET    = 12;
   localparam int PHYS_BITS = 16;
   localparam int IDX_BITS  = OFFSET - PTE_SHIFT;

   typedef struct packed {
      logic [63:0] trans_addr;
      logic        fault;
   } walk_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // virt_addr[47:0], word_index[60:48], word_data[124:61], zero fill
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // op
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // trans_addr[63:0]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // fault
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [ROOT_W-1:0]      csr_wdata = '0;

   logic [63:0]        table_words [0:MEM_WORDS-1];
   logic [ROOT_W-1:0]  root_base = '0;
   walk_result_type    walk_results_due [$];
   walk_result_type    oldest_due;
   logic [VA_W-1:0]    mapped_vas [$];
   int                 mismatch_count = 0;
   int                 words_sent = 0;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   int                 hold_ask = 0;
   int                 hold_seen = 0;
   int                 hold_len = 0;
   int                 hold_left = 0;

   radix_page_table_walk #(
      .LEVEL_COUNT(LEVELS),
      .OFFSET_BITS(OFFSET),
      .PHYS_ADDR_BITS(PHYS_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("%0t timeout with %0d results outstanding", $time, walk_results_due.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic walk_result_type walk_tables(input logic [VA_W-1:0] va);
      walk_result_type res;
      logic [63:0]  lim;
      logic [63:0]  base;
      logic [63:0]  entry_addr;
      logic [63:0]  entry;
      logic [IDX_BITS-1:0] idx;
      res.trans_addr = '0;
      res.fault = 1'b1;
      lim = (PHYS_BITS < 16) ? (64'd1 << PHYS_BITS) : 64'(MEM_BYTES);
      base = 64'(root_base);
      if (base == 0) return res;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         idx = IDX_BITS'(va >> (OFFSET + (LEVELS - 1 - lvl) * IDX_BITS));
         if (base >= lim) return res;
         entry_addr = base + (64'(idx) << PTE_SHIFT);
         if (entry_addr > lim - 8) return res;
         entry = table_words[entry_addr[15:3]];
         if (!entry[0]) return res;
         base = entry & ~((64'd1 << OFFSET) - 1);
      end
      res.trans_addr = base + (64'(va) & ((64'd1 << OFFSET) - 1));
      res.fault = 1'b0;
      return res;
   endfunction

   function automatic logic [VA_W-1:0] va_of(input int i0, input int i1, input int i2,
                                            input int i3, input int off);
      return {IDX_BITS'(i0), IDX_BITS'(i1), IDX_BITS'(i2), IDX_BITS'(i3), OFFSET'(off)};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_seen != hold_ask) begin
         hold_seen = hold_ask;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (walk_results_due.size() == 0) begin
            $display("%0t mismatch: expected no word, actual trans_addr %h fault %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            oldest_due = walk_results_due.pop_front();
            if (rsp_tdata !== oldest_due.trans_addr || rsp_tuser !== oldest_due.fault) begin
               $display("%0t mismatch: expected trans_addr %h fault %b, %s %h fault %b",
                        $time, oldest_due.trans_addr, oldest_due.fault,
                        "actual trans_addr", rsp_tdata, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_word(input logic op, input logic [VA_W-1:0] va,
                            input logic [WORD_IDX_W-1:0] widx, input logic [DATA_W-1:0] wdata);
      walk_result_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, wdata, widx, va};
      do @(posedge clock); while (!req_tready);
      if (op == OP_WRITE) begin
         table_words[widx] = wdata;
         res = '0;
      end else begin
         res = walk_tables(va);
      end
      walk_results_due.push_back(res);
      words_sent++;
   endtask

   task automatic write_entry(input int widx, input logic [63:0] wdata);
      send_word(OP_WRITE, VA_W'(rand64()), WORD_IDX_W'(widx), wdata);
   endtask

   task automatic translate(input logic [VA_W-1:0] va);
      send_word(OP_TRANSLATE, va, WORD_IDX_W'($urandom), rand64());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (walk_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_root(input logic [ROOT_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      root_base = value;
   endtask

   // writes up to one entry per level along va's walk, mostly valid tables in range
   task automatic build_path(input logic [VA_W-1:0] va);
      logic [63:0] base;
      logic [63:0] entry_addr;
      logic [63:0] entry;
      logic [IDX_BITS-1:0] idx;
      base = 64'(root_base);
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         idx = IDX_BITS'(va >> (OFFSET + (LEVELS - 1 - lvl) * IDX_BITS));
         entry_addr = base + (64'(idx) << PTE_SHIFT);
         entry = rand64();
         if (lvl < LEVELS - 1 && $urandom_range(99) >= 4) entry[63:16] = '0;
         entry[0] = ($urandom_range(99) >= 5);
         write_entry(int'(entry_addr[15:3]), entry);
         base = entry & ~((64'd1 << OFFSET) - 1);
         if (base >= 64'(MEM_BYTES)) break;
      end
      mapped_vas.push_back(va);
      if (mapped_vas.size() > 48) void'(mapped_vas.pop_front());
   endtask

   task automatic run_walk_mix(input int words, input int idle, input int stall);
      logic [VA_W-1:0] va;
      int first;
      int pick;
      idle_pct = idle;
      stall_pct = stall;
      first = words_sent;
      while (words_sent - first < words) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            va = VA_W'(rand64());
            build_path(va);
            repeat ($urandom_range(1, 3)) begin
               va[OFFSET-1:0] = OFFSET'($urandom);
               translate(va);
            end
         end else if (pick < 75 && mapped_vas.size() > 0) begin
            va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
            case ($urandom_range(3))
               0: va[OFFSET-1:0] = OFFSET'($urandom);
               1: va = va ^ (VA_W'(1) << $urandom_range(VA_W - 1));
               2: va[OFFSET+IDX_BITS-1:OFFSET] = IDX_BITS'($urandom);
               default: ;
            endcase
            translate(va);
         end else if (pick < 88) begin
            write_entry($urandom_range(MEM_WORDS - 1), rand64());
         end else begin
            translate(VA_W'(rand64()));
         end
      end
      wait_drained();
   endtask

   task automatic test_reset_state();
      translate('0);
      translate('1);
      wait_drained();
   endtask

   task automatic test_directed_walks();
      set_root(16'h1000);
      // frames 2, 3, 4 hold the lower tables; junk in the flag bits must be masked
      write_entry(512, 64'h0000_0000_0000_2FFF);
      write_entry(1024 + 5, 64'h3001);
      write_entry(3 * 512 + 9, 64'h4001);
      write_entry(4 * 512 + 511, 64'hFFFF_FFFF_FFFF_F001);
      translate(va_of(0, 5, 9, 511, 12'hABC));
      translate(va_of(0, 5, 9, 511, 12'hFFF));
      // missing entries at the root and at the last level
      translate(va_of(1, 5, 9, 511, 0));
      translate(va_of(0, 5, 9, 510, 0));
      // valid bit cleared in the middle of the walk
      write_entry(3 * 512 + 9, 64'h4000);
      translate(va_of(0, 5, 9, 511, 12'h001));
      write_entry(3 * 512 + 9, 64'h4001);
      // next table just past the memory
      write_entry(514, 64'h1_0001);
      translate(va_of(2, 0, 0, 0, 0));
      write_entry(MEM_WORDS - 1, '1);
      write_entry(0, '0);
      wait_drained();
   endtask

   task automatic test_root_extremes();
      // top root entry is the last word, which points outside the memory
      set_root(16'hF000);
      translate(va_of(511, 0, 0, 0, 0));
      wait_drained();
      // low address bits of the root are dropped when reading the entry
      set_root(16'h1004);
      translate(va_of(0, 5, 9, 511, 12'h123));
      wait_drained();
      set_root(16'hFFFF);
      translate(va_of(0, 0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_random_phases();
      set_root(16'h1000);
      run_walk_mix(250, 0, 0);
      set_root(16'hF000);
      run_walk_mix(250, 52, 0);
      set_root(16'h2004);
      run_walk_mix(250, 0, 52);
      set_root(ROOT_W'($urandom_range(1, 16'hEFFF)));
      run_walk_mix(250, 37, 37);
   endtask

   task automatic test_backpressure();
      set_root(16'h3000);
      idle_pct = 0;
      stall_pct = 0;
      hold_len = 300;
      hold_ask++;
      repeat (2) begin
         build_path(VA_W'(rand64()));
         translate(mapped_vas[mapped_vas.size() - 1]);
      end
      // sender holds back until the block has emptied
      wait_drained();
      stall_pct = 52;
      repeat (2) begin
         build_path(VA_W'(rand64()));
         translate(mapped_vas[mapped_vas.size() - 1]);
      end
      wait_drained();
      stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < MEM_WORDS; i++) table_words[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_walks();
      test_root_extremes();
      test_backpressure();
      test_random_phases();
      wait_drained();
      repeat (4 * (LEVELS + 1)) @(posedge clock);
      $display("covered %0d words: table writes, full and partial walks, every fault kind",
               words_sent);
      $display("roots zero, unaligned and at the top; idle, stall and long hold-off phases");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
src/ptw_pkg.sv
src/ptw_ram.sv
src/radix_page_table_walk.sv
tb/radix_page_table_walk_test.sv
